// ===== hdl/rbvi_pkg.sv =====
// shared types, codes and fixed-point helpers for the rigid body velocity integrator
`timescale 1ns / 1ps

package rbvi_pkg;

    // slow ticks in a row before the body falls asleep
    localparam logic [7:0] SLEEP_TICKS = 8'd30;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // command codes carried in s_tuser
    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_FORCE   = 3'd1,
        CMD_TORQUE  = 3'd2,
        CMD_IMPULSE = 3'd3,
        CMD_SET_VEL = 3'd4,
        CMD_SET_SPIN = 3'd5,
        CMD_WAKE    = 3'd6,
        CMD_SLEEP   = 3'd7
    } cmd_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_INV_MASS  = 3'd1,
        REG_INV_INER  = 3'd2,
        REG_DECAY     = 3'd3,
        REG_MAX_SPIN  = 3'd4,
        REG_SLEEP_SQ  = 3'd5,
        REG_GRAVITY   = 3'd6,
        REG_COM       = 3'd7
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISP,
        ST_TK0, ST_TK1, ST_TK2, ST_TK3, ST_TK4, ST_TK5, ST_TK6, ST_TK7, ST_TK8,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
        ST_Q0, ST_Q1,
        ST_CLAMP,
        ST_DONE
    } state_t;

    // operand pair for the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DX, MUL_DY, MUL_DW,
        MUL_SQX, MUL_SQY,
        MUL_CRA, MUL_CRB,
        MUL_PX, MUL_PY, MUL_PW,
        MUL_TQ
    } mul_sel_t;

    // write-back operation on the state registers
    typedef enum logic [4:0] {
        WB_NONE,
        WB_GRAV,
        WB_DX, WB_DY, WB_DW,
        WB_SQX, WB_SQY, WB_SLEEP_CHK,
        WB_CRA, WB_CRB,
        WB_PX, WB_PY, WB_PW,
        WB_CLAMP,
        WB_SETV, WB_SETW, WB_WAKE, WB_SLEEP,
        WB_IGN
    } wb_op_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        wb_op_t   wb_op;
        logic     capture;
    } dp_cmd_t;

    typedef struct packed {
        logic refused;
        logic fixed_rot;
    } dp_stat_t;

    // saturate a 33-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
        if (s[32] != s[31])
            return s[32] ? S32_MIN : S32_MAX;
        return s[31:0];
    endfunction

    // saturating 32-bit add
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    // product >> 16 (floor), saturated to 32 bits
    function automatic logic signed [31:0] sat_q16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p >>> 16;
        if (&t[65:31] || ~|t[65:31])
            return t[31:0];
        return t[65] ? S32_MIN : S32_MAX;
    endfunction

    // cross product >> 8 (floor), saturated to 32 bits
    function automatic logic signed [31:0] sat_cross(input logic signed [49:0] v);
        logic signed [49:0] t;
        t = v >>> 8;
        if (&t[49:31] || ~|t[49:31])
            return t[31:0];
        return t[49] ? S32_MIN : S32_MAX;
    endfunction

endpackage

// ===== hdl/rbvi_ctrl.sv =====
// sequencer for the velocity integrator: steps the datapath through each command
`timescale 1ns / 1ps

module rbvi_ctrl
    import rbvi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic [2:0] s_cmd,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t dp_stat,
    output dp_cmd_t  dp_cmd
);

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  state_next = accept ? ST_DISP : ST_IDLE;
            ST_DISP:
            begin
                unique case (cmd_reg)
                    CMD_TICK:    state_next = dp_stat.refused ? ST_DONE : ST_TK0;
                    CMD_FORCE,
                    CMD_IMPULSE: state_next = dp_stat.refused ? ST_DONE : ST_P0;
                    CMD_TORQUE:  state_next = (dp_stat.refused || dp_stat.fixed_rot) ?
                                              ST_DONE : ST_Q0;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_TK0:   state_next = ST_TK1;
            ST_TK1:   state_next = ST_TK2;
            ST_TK2:   state_next = ST_TK3;
            ST_TK3:   state_next = ST_TK4;
            ST_TK4:   state_next = ST_TK5;
            ST_TK5:   state_next = ST_TK6;
            ST_TK6:   state_next = ST_TK7;
            ST_TK7:   state_next = ST_TK8;
            ST_TK8:   state_next = ST_DONE;
            ST_P0:    state_next = ST_P1;
            ST_P1:    state_next = ST_P2;
            ST_P2:    state_next = ST_P3;
            ST_P3:    state_next = ST_P4;
            ST_P4:    state_next = ST_P5;
            ST_P5:    state_next = (cmd_reg == CMD_IMPULSE) ? ST_CLAMP : ST_DONE;
            ST_Q0:    state_next = ST_Q1;
            ST_Q1:    state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_DONE;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath commands per state
    always_comb
    begin
        dp_cmd.load    = accept;
        dp_cmd.mul_sel = MUL_NONE;
        dp_cmd.wb_op   = WB_NONE;
        dp_cmd.capture = 1'b0;
        unique case (state_reg)
            ST_IDLE: ;
            ST_DISP:
            begin
                unique case (cmd_reg)
                    CMD_TICK,
                    CMD_FORCE,
                    CMD_IMPULSE:  dp_cmd.wb_op = dp_stat.refused ? WB_IGN : WB_NONE;
                    CMD_TORQUE:   dp_cmd.wb_op = (dp_stat.refused || dp_stat.fixed_rot) ?
                                                 WB_IGN : WB_NONE;
                    CMD_SET_VEL:  dp_cmd.wb_op = WB_SETV;
                    CMD_SET_SPIN: dp_cmd.wb_op = WB_SETW;
                    CMD_WAKE:     dp_cmd.wb_op = WB_WAKE;
                    CMD_SLEEP:    dp_cmd.wb_op = WB_SLEEP;
                    default:      dp_cmd.wb_op = WB_NONE;
                endcase
            end
            ST_TK0: dp_cmd.wb_op = WB_GRAV;
            ST_TK1: dp_cmd.mul_sel = MUL_DX;
            ST_TK2:
            begin
                dp_cmd.mul_sel = MUL_DY;
                dp_cmd.wb_op   = WB_DX;
            end
            ST_TK3:
            begin
                dp_cmd.mul_sel = MUL_DW;
                dp_cmd.wb_op   = WB_DY;
            end
            ST_TK4:
            begin
                dp_cmd.mul_sel = MUL_SQX;
                dp_cmd.wb_op   = WB_DW;
            end
            ST_TK5:
            begin
                dp_cmd.mul_sel = MUL_SQY;
                dp_cmd.wb_op   = WB_SQX;
            end
            ST_TK6: dp_cmd.wb_op = WB_SQY;
            ST_TK7: dp_cmd.wb_op = WB_CLAMP;
            ST_TK8: dp_cmd.wb_op = WB_SLEEP_CHK;
            ST_P0:  dp_cmd.mul_sel = MUL_CRA;
            ST_P1:
            begin
                dp_cmd.mul_sel = MUL_CRB;
                dp_cmd.wb_op   = WB_CRA;
            end
            ST_P2:
            begin
                dp_cmd.mul_sel = MUL_PX;
                dp_cmd.wb_op   = WB_CRB;
            end
            ST_P3:
            begin
                dp_cmd.mul_sel = MUL_PY;
                dp_cmd.wb_op   = WB_PX;
            end
            ST_P4:
            begin
                dp_cmd.mul_sel = MUL_PW;
                dp_cmd.wb_op   = WB_PY;
            end
            ST_P5:    dp_cmd.wb_op = WB_PW;
            ST_Q0:    dp_cmd.mul_sel = MUL_TQ;
            ST_Q1:    dp_cmd.wb_op = WB_PW;
            ST_CLAMP: dp_cmd.wb_op = WB_CLAMP;
            ST_DONE:  dp_cmd.capture = out_free;
            default: ;
        endcase
    end

    // output beat valid flag
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (dp_cmd.capture)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    assign cmd_next = accept ? cmd_t'(s_cmd) : cmd_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmd_reg      <= CMD_TICK;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // a result beat only appears after the finishing step
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output valid rose outside the finishing step");

    // an accepted beat always starts dispatch
    a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DISP)
        else $error("accepted beat did not reach dispatch");

    // the output register is never overwritten while a beat waits
    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.capture |-> (!m_tvalid_reg || m_tready))
        else $error("result captured over a pending beat");

endmodule

// ===== hdl/rbvi_dp.sv =====
// datapath: configuration, body state, shared multiplier and output register
`timescale 1ns / 1ps

module rbvi_dp
    import rbvi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  dp_cmd_t            dp_cmd,
    output dp_stat_t           dp_stat,
    output logic signed [31:0] velocity_x,
    output logic signed [31:0] velocity_y,
    output logic signed [31:0] spin,
    output logic               asleep,
    output logic               ignored
);

    // configuration registers
    logic [3:0]  mode_reg;
    logic [31:0] inv_mass_reg;
    logic [31:0] inv_iner_reg;
    logic [31:0] decay_reg;
    logic [30:0] max_spin_reg;
    logic [62:0] sleep_sq_reg;
    logic [63:0] gravity_reg;
    logic [31:0] com_reg;

    // body state
    logic signed [31:0] vx_reg, vx_next;
    logic signed [31:0] vy_reg, vy_next;
    logic signed [31:0] w_reg, w_next;
    logic               sleep_reg, sleep_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic               ign_reg, ign_next;

    // working registers
    logic signed [31:0] fx_reg, fy_reg;
    logic signed [15:0] px_reg, py_reg;
    logic signed [65:0] prod_reg;
    logic signed [49:0] cross_reg, cross_next;
    logic signed [31:0] c_reg, c_next;
    logic [63:0]        acc_reg, acc_next;

    // output register
    logic signed [31:0] out_vx_reg, out_vy_reg, out_w_reg;
    logic               out_sleep_reg, out_ign_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [16:0] rx, ry;
    logic signed [15:0] com_x, com_y;
    logic signed [32:0] w_mag;
    logic [7:0]         cnt_inc;

    assign dp_stat.refused   = (mode_reg[1:0] != 2'd0) || sleep_reg;
    assign dp_stat.fixed_rot = mode_reg[3];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 4'd4;
            inv_mass_reg <= 32'd65536;
            inv_iner_reg <= 32'd65536;
            decay_reg    <= 32'hFFF5_FFF5;
            max_spin_reg <= 31'd6553600;
            sleep_sq_reg <= 63'd429497;
            gravity_reg  <= 64'd0;
            com_reg      <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_MODE:     mode_reg     <= cfg_data[3:0];
                REG_INV_MASS: inv_mass_reg <= cfg_data[31:0];
                REG_INV_INER: inv_iner_reg <= cfg_data[31:0];
                REG_DECAY:    decay_reg    <= cfg_data[31:0];
                REG_MAX_SPIN: max_spin_reg <= cfg_data[30:0];
                REG_SLEEP_SQ: sleep_sq_reg <= cfg_data[62:0];
                REG_GRAVITY:  gravity_reg  <= cfg_data;
                REG_COM:      com_reg      <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // lever arm from center of mass, Q8.8 in 17 bits
    assign com_x = com_reg[31:16];
    assign com_y = com_reg[15:0];
    assign rx    = {px_reg[15], px_reg} - {com_x[15], com_x};
    assign ry    = {py_reg[15], py_reg} - {com_y[15], com_y};

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (dp_cmd.mul_sel)
            MUL_DX:
            begin
                mul_a = {vx_reg[31], vx_reg};
                mul_b = {17'd0, decay_reg[31:16]};
            end
            MUL_DY:
            begin
                mul_a = {vy_reg[31], vy_reg};
                mul_b = {17'd0, decay_reg[31:16]};
            end
            MUL_DW:
            begin
                mul_a = {w_reg[31], w_reg};
                mul_b = {17'd0, decay_reg[15:0]};
            end
            MUL_SQX:
            begin
                mul_a = {vx_reg[31], vx_reg};
                mul_b = {vx_reg[31], vx_reg};
            end
            MUL_SQY:
            begin
                mul_a = {vy_reg[31], vy_reg};
                mul_b = {vy_reg[31], vy_reg};
            end
            MUL_CRA:
            begin
                mul_a = {{16{ry[16]}}, ry};
                mul_b = {fx_reg[31], fx_reg};
            end
            MUL_CRB:
            begin
                mul_a = {{16{rx[16]}}, rx};
                mul_b = {fy_reg[31], fy_reg};
            end
            MUL_PX:
            begin
                mul_a = {fx_reg[31], fx_reg};
                mul_b = {1'b0, inv_mass_reg};
            end
            MUL_PY:
            begin
                mul_a = {fy_reg[31], fy_reg};
                mul_b = {1'b0, inv_mass_reg};
            end
            MUL_PW:
            begin
                mul_a = {c_reg[31], c_reg};
                mul_b = {1'b0, inv_iner_reg};
            end
            MUL_TQ:
            begin
                mul_a = {fx_reg[31], fx_reg};
                mul_b = {1'b0, inv_iner_reg};
            end
            default: ;
        endcase
    end

    // spin magnitude for the clamp
    assign w_mag   = w_reg[31] ? -{w_reg[31], w_reg} : {w_reg[31], w_reg};
    assign cnt_inc = (cnt_reg == 8'hFF) ? cnt_reg : cnt_reg + 8'd1;

    // state write-back
    always_comb
    begin
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        w_next     = w_reg;
        sleep_next = sleep_reg;
        cnt_next   = cnt_reg;
        ign_next   = dp_cmd.load ? 1'b0 : ign_reg;
        cross_next = cross_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        unique case (dp_cmd.wb_op)
            WB_NONE: ;
            WB_GRAV:
            begin
                if (mode_reg[2])
                begin
                    vx_next = sat_add(vx_reg, gravity_reg[63:32]);
                    vy_next = sat_add(vy_reg, gravity_reg[31:0]);
                end
            end
            WB_DX:  vx_next = sat_q16(prod_reg);
            WB_DY:  vy_next = sat_q16(prod_reg);
            WB_DW:  w_next  = sat_q16(prod_reg);
            WB_SQX: acc_next = prod_reg[63:0];
            WB_SQY: acc_next = acc_reg + prod_reg[63:0];
            WB_SLEEP_CHK:
            begin
                if (acc_reg < {1'b0, sleep_sq_reg})
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= SLEEP_TICKS)
                    begin
                        sleep_next = 1'b1;
                        vx_next    = '0;
                        vy_next    = '0;
                        w_next     = '0;
                    end
                end
                else
                    cnt_next = '0;
            end
            WB_CRA: cross_next = prod_reg[49:0];
            WB_CRB: c_next = sat_cross(cross_reg - prod_reg[49:0]);
            WB_PX:  vx_next = sat_add(vx_reg, sat_q16(prod_reg));
            WB_PY:  vy_next = sat_add(vy_reg, sat_q16(prod_reg));
            WB_PW:  w_next  = sat_add(w_reg, sat_q16(prod_reg));
            WB_CLAMP:
            begin
                if (mode_reg[3])
                    w_next = '0;
                else if (w_mag > {2'b00, max_spin_reg})
                    w_next = w_reg[31] ? -$signed({1'b0, max_spin_reg})
                                       : $signed({1'b0, max_spin_reg});
            end
            WB_SETV:
            begin
                vx_next    = fx_reg;
                vy_next    = fy_reg;
                sleep_next = 1'b0;
                cnt_next   = '0;
            end
            WB_SETW:
            begin
                w_next     = fx_reg;
                sleep_next = 1'b0;
                cnt_next   = '0;
            end
            WB_WAKE:
            begin
                sleep_next = 1'b0;
                cnt_next   = '0;
            end
            WB_SLEEP:
            begin
                sleep_next = 1'b1;
                vx_next    = '0;
                vy_next    = '0;
                w_next     = '0;
            end
            WB_IGN: ign_next = 1'b1;
            default: ;
        endcase
    end

    // body state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg    <= '0;
            vy_reg    <= '0;
            w_reg     <= '0;
            sleep_reg <= 1'b0;
            cnt_reg   <= '0;
            ign_reg   <= 1'b0;
        end
        else
        begin
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            w_reg     <= w_next;
            sleep_reg <= sleep_next;
            cnt_reg   <= cnt_next;
            ign_reg   <= ign_next;
        end
    end

    // input latch, product and intermediates
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            fx_reg <= vec_x;
            fy_reg <= vec_y;
            px_reg <= point_x;
            py_reg <= point_y;
        end
        if (dp_cmd.mul_sel != MUL_NONE)
            prod_reg <= mul_a * mul_b;
        cross_reg <= cross_next;
        c_reg     <= c_next;
        acc_reg   <= acc_next;
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            out_vx_reg    <= vx_reg;
            out_vy_reg    <= vy_reg;
            out_w_reg     <= w_reg;
            out_sleep_reg <= sleep_reg;
            out_ign_reg   <= ign_reg;
        end
    end

    assign velocity_x = out_vx_reg;
    assign velocity_y = out_vy_reg;
    assign spin       = out_w_reg;
    assign asleep     = out_sleep_reg;
    assign ignored    = out_ign_reg;

    // falling asleep always leaves the body at rest
    a_sleep_at_rest: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sleep_reg) |-> (vx_reg == 0 && vy_reg == 0 && w_reg == 0))
        else $error("body fell asleep while moving");

endmodule

// ===== hdl/rigid_body_velocity_integrator_core.sv =====
// top level of the rigid body velocity integrator
`timescale 1ns / 1ps

// Integrates one 2D body's velocity and spin in Q16.16, one command per input
// beat, one result beat per command. A single 33x33 multiplier with a
// registered product is shared by every multiply step; tick, force at point,
// impulse at point and torque use it, while set velocity, set spin, wake, sleep
// or a refused command finish without it. The result lands in an output
// register, so a new beat is taken while the previous result waits on m_tready.
// Configuration is written through the cfg port while no command is in flight,
// which the user must keep to, as the block does not enforce it; cfg_ready is always high.

module rigid_body_velocity_integrator_core
    import rbvi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // command input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // vec_x[31:0], vec_y[63:32], point_x[79:64], point_y[95:80]
    input  logic [2:0]  s_tuser,  // cmd[2:0]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // velocity_x[31:0], velocity_y[63:32], spin[95:64]
    output logic [1:0]  m_tuser   // asleep[0], ignored[1]
);

    dp_cmd_t            dp_cmd;
    dp_stat_t           dp_stat;
    logic signed [31:0] velocity_x, velocity_y, spin;
    logic               asleep, ignored;

    assign cfg_ready = 1'b1;

    // command sequencer
    rbvi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    // arithmetic and state
    rbvi_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .vec_x      (s_tdata[31:0]),
        .vec_y      (s_tdata[63:32]),
        .point_x    (s_tdata[79:64]),
        .point_y    (s_tdata[95:80]),
        .dp_cmd     (dp_cmd),
        .dp_stat    (dp_stat),
        .velocity_x (velocity_x),
        .velocity_y (velocity_y),
        .spin       (spin),
        .asleep     (asleep),
        .ignored    (ignored)
    );

    // result beat packing
    assign m_tdata = {spin, velocity_y, velocity_x};
    assign m_tuser = {ignored, asleep};

endmodule
